// ----- rtl/sigmoid_cross_entropy_loss_defines.svh -----
`ifndef SIGMOID_CROSS_ENTROPY_LOSS_DEFINES_SVH
`define SIGMOID_CROSS_ENTROPY_LOSS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCE_ASSERT_NOW(LBL, CLK, RST_N, ANTE, CONS) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
		else $error("sigmoid cross-entropy check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCE_ASSERT_NEXT(LBL, CLK, RST_N, ANTE, CONS) \
	LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
		else $error("sigmoid cross-entropy check failed");

`endif

// ----- rtl/sce_pkg.sv -----
`default_nettype none

package sce_pkg;

	localparam int LOGIT_W = 16;
	localparam int TARGET_W = 11;
	localparam int GRAD_W = 12;
	localparam int MEAN_W = 16;
	localparam int COUNT_W = 32;
	localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFFFF;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF = 64'd1 << 29;

	typedef struct packed {
		logic signed [LOGIT_W-1:0] logit;
		logic [TARGET_W-1:0] target;
		logic last_item;
	} item_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic [MEAN_W-1:0] mean_loss;
		logic loss_valid;
		logic end_of_batch;
	} result_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// The functions below only build the ROM contents at elaboration.
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] q30_mul(input logic [63:0] u, input logic [63:0] v);
		logic [63:0] prod;
		prod = u * v;
		return (prod + Q30_HALF) >> 30;
	endfunction

	function automatic logic [63:0] exp_lsb(input int frac);
		logic [63:0] acc;
		logic [63:0] t;
		acc = Q30_ONE;
		t = Q30_ONE;
		for (int k = 1; k <= 6; k++) begin
			t = udiv(t >> frac, 64'(k));
			if ((k & 1) != 0) begin
				acc = acc - t;
			end else begin
				acc = acc + t;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] q30_pow(input logic [63:0] base, input logic [15:0] p);
		logic [63:0] r;
		logic [63:0] b2;
		r = Q30_ONE;
		b2 = base;
		for (int b = 0; b < 16; b++) begin
			if (p[b]) begin
				r = q30_mul(r, b2);
			end
			b2 = q30_mul(b2, b2);
		end
		return r;
	endfunction

	function automatic logic [63:0] q30_ln1p(input logic [63:0] e);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] sum;
		logic [63:0] t;
		z = udiv(e << 30, (Q30_ONE << 1) + e);
		z2 = (z * z) >> 30;
		sum = z;
		t = z;
		for (int k = 1; k <= 15; k++) begin
			t = (t * z2) >> 30;
			sum = sum + udiv(t, 64'(2 * k + 1));
		end
		return sum << 1;
	endfunction

	function automatic logic [63:0] bin_exp(input int i, input int frac, input int depth);
		logic [63:0] p;
		p = udiv(64'(2 * i + 1) * 64'd16384, 64'(depth));
		return q30_pow(exp_lsb(frac), p[15:0]);
	endfunction

	function automatic logic [63:0] sig_entry(input int i, input int frac, input int depth);
		logic [63:0] e;
		logic [63:0] den;
		e = bin_exp(i, frac, depth);
		den = Q30_ONE + e;
		return udiv((e << frac) + (den >> 1), den);
	endfunction

	function automatic logic [63:0] sp_entry(input int i, input int frac, input int depth);
		logic [63:0] e;
		e = bin_exp(i, frac, depth);
		return (q30_ln1p(e) + (64'd1 << (29 - frac))) >> (30 - frac);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sce_front.sv -----
`default_nettype none

module sce_front #(
	parameter int FRAC_BITS = 10,
	parameter int TABLE_DEPTH = 1024,
	parameter int IDX_W = 10,
	parameter int BASE_W = 28,
	parameter int QW = 51
) (
	input wire logic item_valid,
	output logic item_ready,
	input wire sce_pkg::item_t item_data,
	output logic q_valid,
	input wire logic q_ready,
	output logic [QW-1:0] q_data
);

	localparam int PW = sce_pkg::LOGIT_W + IDX_W + 1;
	localparam int ONE_I = 1 << FRAC_BITS;

	logic [sce_pkg::LOGIT_W-1:0] ax;
	logic [PW-1:0] scaled;
	logic [IDX_W+1:0] idx_raw;
	logic [IDX_W-1:0] idx;
	logic [sce_pkg::TARGET_W-1:0] y;
	logic signed [BASE_W-1:0] pos_term;
	logic signed [BASE_W-1:0] xy;
	logic signed [BASE_W-1:0] base;

	assign item_ready = q_ready;
	assign q_valid = item_valid;

	always_comb begin
		ax = item_data.logit[sce_pkg::LOGIT_W-1] ? sce_pkg::LOGIT_W'(-item_data.logit)
			: sce_pkg::LOGIT_W'(item_data.logit);
		scaled = PW'(ax) * PW'(TABLE_DEPTH);
		idx_raw = scaled[PW-1:15];
		if (idx_raw > (IDX_W + 2)'(TABLE_DEPTH - 1)) begin
			idx = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			idx = idx_raw[IDX_W-1:0];
		end

		if (32'(item_data.target) > 32'(ONE_I)) begin
			y = sce_pkg::TARGET_W'(ONE_I);
		end else begin
			y = item_data.target;
		end

		pos_term = item_data.logit[sce_pkg::LOGIT_W-1] ? '0
			: (BASE_W'(item_data.logit) <<< FRAC_BITS);
		xy = BASE_W'(item_data.logit) * BASE_W'($signed({1'b0, y}));
		base = pos_term - xy;
	end

	assign q_data = {idx, item_data.logit[sce_pkg::LOGIT_W-1], y, base, item_data.last_item};

endmodule

`default_nettype wire

// ----- rtl/sce_queue.sv -----
`default_nettype none

module sce_queue #(
	parameter int W = 51,
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire logic [W-1:0] push_data,
	output logic pop_valid,
	input wire logic pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sce_div.sv -----
`default_nettype none

module sce_div #(
	parameter int SUM_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sce_pkg::div_ctrl_t ctrl,
	output sce_pkg::div_stat_t stat,
	input wire logic [SUM_BITS-1:0] dividend,
	input wire logic [sce_pkg::COUNT_W-1:0] divisor,
	output logic [SUM_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_BITS);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [STEP_W-1:0] step_q;
	logic [sce_pkg::COUNT_W-1:0] rem_q;
	logic [sce_pkg::COUNT_W-1:0] dvs_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [sce_pkg::COUNT_W:0] rem_sh;
	logic [sce_pkg::COUNT_W:0] rem_sub;
	logic fits;

	assign stat.busy = (state_q == ST_RUN);
	assign stat.done = (state_q == ST_DONE);
	assign quotient = quo_q;

	always_comb begin
		rem_sh = {rem_q, quo_q[SUM_BITS-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctrl.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (state_q == ST_RUN) begin
			rem_q <= fits ? rem_sub[sce_pkg::COUNT_W-1:0] : rem_sh[sce_pkg::COUNT_W-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_RUN;
						step_q <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_BITS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctrl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sce_back.sv -----
`default_nettype none

module sce_back #(
	parameter int FRAC_BITS = 10,
	parameter int TABLE_DEPTH = 1024,
	parameter int SUM_BITS = 48,
	parameter int IDX_W = 10,
	parameter int BASE_W = 28,
	parameter int QW = 51
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire logic [QW-1:0] q_data,
	output sce_pkg::div_ctrl_t div_ctrl,
	input wire sce_pkg::div_stat_t div_stat,
	output logic [SUM_BITS-1:0] div_dividend,
	output logic [sce_pkg::COUNT_W-1:0] div_divisor,
	input wire logic [SUM_BITS-1:0] div_quotient,
	output logic res_valid,
	input wire logic res_ready,
	output sce_pkg::result_t res_data
);

	localparam int AW = ((SUM_BITS > BASE_W) ? SUM_BITS : BASE_W) + 1;
	localparam int DW = FRAC_BITS + 13;
	localparam int RW = SUM_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1 << FRAC_BITS);

	logic [FRAC_BITS-1:0] sig_rom [TABLE_DEPTH];
	logic [FRAC_BITS-1:0] sp_rom [TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_rom
		localparam logic [63:0] SIG_V = sce_pkg::sig_entry(i, FRAC_BITS, TABLE_DEPTH);
		localparam logic [63:0] SP_V = sce_pkg::sp_entry(i, FRAC_BITS, TABLE_DEPTH);
		assign sig_rom[i] = SIG_V[FRAC_BITS-1:0];
		assign sp_rom[i] = SP_V[FRAC_BITS-1:0];
	end

	logic [IDX_W-1:0] h_idx;
	logic h_neg;
	logic [sce_pkg::TARGET_W-1:0] h_y;
	logic signed [BASE_W-1:0] h_base;
	logic h_last;

	logic v_s1;
	logic neg_s1;
	logic [sce_pkg::TARGET_W-1:0] y_s1;
	logic signed [BASE_W-1:0] base_s1;
	logic last_s1;
	logic [FRAC_BITS-1:0] sig_s1;
	logic [FRAC_BITS-1:0] sp_s1;

	logic [SUM_BITS-1:0] sum_q;
	logic [sce_pkg::COUNT_W-1:0] cnt_q;
	logic [sce_pkg::GRAD_W-1:0] pend_grad_q;
	logic res_valid_q;
	sce_pkg::result_t res_q;

	logic div_idle;
	logic adv_s1;
	logic pop;
	logic fin;
	logic [FRAC_BITS:0] sig_val;
	logic [DW-1:0] diff;
	logic [sce_pkg::GRAD_W-1:0] grad;
	logic signed [BASE_W-1:0] term_s;
	logic [BASE_W-1:0] term_u;
	logic [AW-1:0] add;
	logic [SUM_BITS-1:0] sum_next;
	logic [sce_pkg::COUNT_W-1:0] cnt_next;
	logic [RW-1:0] rnd;
	logic [RW-1:0] sh;
	logic [sce_pkg::MEAN_W-1:0] mean;

	assign {h_idx, h_neg, h_y, h_base, h_last} = q_data;

	assign div_idle = !div_stat.busy && !div_stat.done;
	assign adv_s1 = v_s1 && div_idle && (last_s1 || !res_valid_q || res_ready);
	assign q_ready = !v_s1 || adv_s1;
	assign pop = q_valid && q_ready;
	assign fin = div_stat.done && (!res_valid_q || res_ready);

	always_comb begin
		sig_val = neg_s1 ? {1'b0, sig_s1} : ONE_F - {1'b0, sig_s1};
		diff = DW'(sig_val) - DW'(y_s1);
		grad = diff[sce_pkg::GRAD_W-1:0];

		term_s = base_s1 + $signed(BASE_W'(sp_s1) << FRAC_BITS);
		term_u = term_s[BASE_W-1] ? '0 : term_s;
		add = AW'(sum_q) + AW'(term_u);
		sum_next = (add > AW'({SUM_BITS{1'b1}})) ? '1 : add[SUM_BITS-1:0];
		cnt_next = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

		rnd = RW'(div_quotient) + RW'(1 << (FRAC_BITS - 1));
		sh = rnd >> FRAC_BITS;
		mean = (sh > RW'(sce_pkg::MEAN_MAX)) ? sce_pkg::MEAN_MAX : sh[sce_pkg::MEAN_W-1:0];
	end

	assign div_ctrl.start = adv_s1 && last_s1;
	assign div_ctrl.ack = fin;
	assign div_dividend = sum_next;
	assign div_divisor = cnt_next;

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_s1 <= h_neg;
			y_s1 <= h_y;
			base_s1 <= h_base;
			last_s1 <= h_last;
			sig_s1 <= sig_rom[h_idx];
			sp_s1 <= sp_rom[h_idx];
		end
		if (adv_s1 && last_s1) begin
			pend_grad_q <= grad;
		end
		if (adv_s1 && !last_s1) begin
			res_q.gradient <= $signed(grad);
			res_q.mean_loss <= '0;
			res_q.loss_valid <= 1'b0;
			res_q.end_of_batch <= 1'b0;
		end else if (fin) begin
			res_q.gradient <= $signed(pend_grad_q);
			res_q.mean_loss <= mean;
			res_q.loss_valid <= 1'b1;
			res_q.end_of_batch <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
			if ((adv_s1 && !last_s1) || fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule

`default_nettype wire

// ----- rtl/sigmoid_cross_entropy_loss.sv -----
// Sigmoid cross-entropy loss with logits. Each (logit, target) pair transfer gives one result
// with the gradient sigmoid(logit) - target; the stable loss term of the pair is added to a
// saturating accumulator, and the result of the pair marked last also carries the batch mean
// loss, after which the accumulator and pair counter start again from zero. Ordinary pairs are
// taken at one per cycle while the queue has room, and pass through the four-entry queue, which
// separates the input side from the table lookup and accumulation, then the lookup register and
// the result register. The pair marked last holds the back end until the one-bit-per-cycle
// restoring divider that forms the mean is done and the result slot is free; the queue keeps
// taking pairs meanwhile until it fills. The sigmoid and softplus tables, built at elaboration
// from the parameters, are read through a registered port indexed by the logit magnitude.
`default_nettype none

module sigmoid_cross_entropy_loss #(
	parameter int FRAC_BITS = 10,
	parameter int TABLE_DEPTH = 1024,
	parameter int SUM_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire sce_pkg::item_t item_data,
	output logic res_valid,
	input wire logic res_ready,
	output sce_pkg::result_t res_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int BASE_W = FRAC_BITS + 18;
	localparam int QW = IDX_W + BASE_W + sce_pkg::TARGET_W + 2;

	logic fq_valid;
	logic fq_ready;
	logic [QW-1:0] fq_data;
	logic qb_valid;
	logic qb_ready;
	logic [QW-1:0] qb_data;
	sce_pkg::div_ctrl_t div_ctrl;
	sce_pkg::div_stat_t div_stat;
	logic [SUM_BITS-1:0] div_dividend;
	logic [sce_pkg::COUNT_W-1:0] div_divisor;
	logic [SUM_BITS-1:0] div_quotient;

	sce_front #(
		.FRAC_BITS(FRAC_BITS),
		.TABLE_DEPTH(TABLE_DEPTH),
		.IDX_W(IDX_W),
		.BASE_W(BASE_W),
		.QW(QW)
	) u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data(item_data),
		.q_valid(fq_valid),
		.q_ready(fq_ready),
		.q_data(fq_data)
	);

	sce_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_data(fq_data),
		.pop_valid(qb_valid),
		.pop_ready(qb_ready),
		.pop_data(qb_data)
	);

	sce_back #(
		.FRAC_BITS(FRAC_BITS),
		.TABLE_DEPTH(TABLE_DEPTH),
		.SUM_BITS(SUM_BITS),
		.IDX_W(IDX_W),
		.BASE_W(BASE_W),
		.QW(QW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(qb_valid),
		.q_ready(qb_ready),
		.q_data(qb_data),
		.div_ctrl(div_ctrl),
		.div_stat(div_stat),
		.div_dividend(div_dividend),
		.div_divisor(div_divisor),
		.div_quotient(div_quotient),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	sce_div #(
		.SUM_BITS(SUM_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(div_ctrl),
		.stat(div_stat),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.quotient(div_quotient)
	);

endmodule

`default_nettype wire

// ----- rtl/sce_checker.sv -----
`default_nettype none
`include "sigmoid_cross_entropy_loss_defines.svh"

module sce_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire sce_pkg::result_t res_data
);

	`SCE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))
	`SCE_ASSERT_NOW(a_flag_pair, clk, arst_n, res_valid, res_data.loss_valid == res_data.end_of_batch)
	`SCE_ASSERT_NOW(a_mean_idle, clk, arst_n, res_valid && !res_data.loss_valid, res_data.mean_loss == '0)

endmodule

bind sigmoid_cross_entropy_loss sce_checker u_sce_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data(res_data)
);

`default_nettype wire

// ----- bench/tb_sigmoid_cross_entropy_loss.sv -----
`timescale 1ns / 1ps

module tb_sigmoid_cross_entropy_loss;

	localparam int FRAC = 10;
	localparam int TAB_DEPTH = 1024;
	localparam int ACC_BITS = 48;
	localparam int RAND_ITEMS = 700;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] FX_ONE = 64'd1 << 30;

	typedef struct {
		sce_pkg::item_t pair;
		bit typed;
		sce_pkg::result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	sce_pkg::item_t item_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	sce_pkg::result_t res_data;

	longint sig_tab[TAB_DEPTH];
	longint soft_tab[TAB_DEPTH];
	logic [63:0] run_loss_sum;
	logic [31:0] run_pair_count;

	sce_pkg::result_t due_results[$];
	stim_row_t stim_table[$];
	sce_pkg::result_t want_res;
	int mismatches = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	sigmoid_cross_entropy_loss dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_data(item_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] fx_mul(logic [63:0] u, logic [63:0] v);
		return (u * v + (64'd1 << 29)) >> 30;
	endfunction

	function automatic logic [63:0] fx_pow(logic [63:0] base, int unsigned p);
		logic [63:0] r;
		r = FX_ONE;
		while (p != 0) begin
			if (p[0]) begin
				r = fx_mul(r, base);
			end
			base = fx_mul(base, base);
			p = p >> 1;
		end
		return r;
	endfunction

	function automatic logic [63:0] fx_log1p(logic [63:0] e);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] acc;
		logic [63:0] t;
		z = (e << 30) / ((FX_ONE << 1) + e);
		z2 = (z * z) >> 30;
		acc = z;
		t = z;
		for (int k = 1; k <= 15; k++) begin
			t = (t * z2) >> 30;
			acc = acc + t / (2 * k + 1);
		end
		return acc << 1;
	endfunction

	task automatic build_tables();
		logic [63:0] g;
		logic [63:0] t;
		logic [63:0] e;
		logic [63:0] den;
		int unsigned p;
		g = FX_ONE;
		t = FX_ONE;
		for (int k = 1; k <= 6; k++) begin
			t = (t >> FRAC) / k;
			if (k % 2 == 1) begin
				g = g - t;
			end else begin
				g = g + t;
			end
		end
		for (int i = 0; i < TAB_DEPTH; i++) begin
			p = ((2 * i + 1) * 16384) / TAB_DEPTH;
			e = fx_pow(g, p);
			den = FX_ONE + e;
			sig_tab[i] = longint'(((e << FRAC) + den / 2) / den);
			soft_tab[i] = longint'((fx_log1p(e) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
		end
	endtask

	function automatic sce_pkg::result_t predict_pair(sce_pkg::item_t it);
		sce_pkg::result_t r;
		longint x;
		longint y;
		longint ax;
		longint sig;
		longint term;
		int idx;
		logic [63:0] sum_max;
		logic [63:0] mean;
		sum_max = (64'd1 << ACC_BITS) - 1;
		x = longint'($signed(it.logit));
		y = longint'(it.target);
		if (y > (1 << FRAC)) begin
			y = 1 << FRAC;
		end
		ax = (x < 0) ? -x : x;
		idx = int'((ax * TAB_DEPTH) >> 15);
		if (idx > TAB_DEPTH - 1) begin
			idx = TAB_DEPTH - 1;
		end
		sig = (x >= 0) ? (1 << FRAC) - sig_tab[idx] : sig_tab[idx];
		term = ((x > 0 ? x : 0) << FRAC) - x * y + (soft_tab[idx] << FRAC);
		if (term < 0) begin
			term = 0;
		end
		if (64'(term) > sum_max - run_loss_sum) begin
			run_loss_sum = sum_max;
		end else begin
			run_loss_sum = run_loss_sum + 64'(term);
		end
		if (run_pair_count != 32'hFFFF_FFFF) begin
			run_pair_count = run_pair_count + 1;
		end
		mean = '0;
		if (it.last_item) begin
			mean = ((run_loss_sum / {32'd0, run_pair_count}) + (64'd1 << (FRAC - 1))) >> FRAC;
			if (mean > 64'd65535) begin
				mean = 64'd65535;
			end
			run_loss_sum = '0;
			run_pair_count = '0;
		end
		r.gradient = 12'(sig - y);
		r.mean_loss = mean[15:0];
		r.loss_valid = it.last_item;
		r.end_of_batch = it.last_item;
		return r;
	endfunction

	task automatic add_row(int lg, int tg, bit lst, bit typed, int grad, int mean);
		stim_row_t row;
		row.pair.logit = 16'(lg);
		row.pair.target = 11'(tg);
		row.pair.last_item = lst;
		row.typed = typed;
		row.res.gradient = 12'(grad);
		row.res.mean_loss = 16'(mean);
		row.res.loss_valid = lst;
		row.res.end_of_batch = lst;
		stim_table.push_back(row);
	endtask

	task automatic offer_pair(sce_pkg::item_t it, bit typed, sce_pkg::result_t want);
		sce_pkg::result_t predicted;
		item_data <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predicted = predict_pair(it);
		due_results.push_back(typed ? want : predicted);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 23) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic logic [15:0] rand_logit();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			1, 2, 3, 4: begin
				if ($urandom_range(0, 1) == 1) begin
					return 16'(-$urandom_range(0, 8191));
				end
				return 16'($urandom_range(0, 8191));
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [10:0] rand_target();
		case ($urandom_range(0, 9))
			8: return ($urandom_range(0, 1) == 1) ? 11'd1024 : 11'd0;
			9: return 11'($urandom_range(1025, 2047));
			default: return 11'($urandom_range(0, 1024));
		endcase
	endfunction

	task automatic report_mismatch(string field, longint want, longint got);
		mismatches++;
		$display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t ns: result transfer with nothing expected, gradient %0d",
					$time, $signed(res_data.gradient));
			end else begin
				want_res = due_results.pop_front();
				if (res_data.gradient !== want_res.gradient) begin
					report_mismatch("gradient", longint'($signed(want_res.gradient)),
						longint'($signed(res_data.gradient)));
				end
				if (res_data.mean_loss !== want_res.mean_loss) begin
					report_mismatch("mean_loss", want_res.mean_loss, res_data.mean_loss);
				end
				if (res_data.loss_valid !== want_res.loss_valid) begin
					report_mismatch("loss_valid", want_res.loss_valid, res_data.loss_valid);
				end
				if (res_data.end_of_batch !== want_res.end_of_batch) begin
					report_mismatch("end_of_batch", want_res.end_of_batch,
						res_data.end_of_batch);
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				res_ready <= quiet || ($urandom_range(0, 99) >= 23);
			end
		end
	end

	initial begin
		sce_pkg::item_t it;
		int sent;
		int blen;
		run_loss_sum = '0;
		run_pair_count = '0;
		build_tables();

		add_row(32767, 1024, 1'b1, 1'b1, 0, 0);
		add_row(32767, 0, 1'b1, 1'b1, 1024, 32767);
		add_row(-32768, 2047, 1'b1, 1'b1, -1024, 32768);
		add_row(-32768, 0, 1'b1, 1'b1, 0, 0);
		add_row(0, 0, 1'b0, 1'b0, 0, 0);
		add_row(0, 1024, 1'b0, 1'b0, 0, 0);
		add_row(0, 512, 1'b0, 1'b0, 0, 0);
		add_row(1, 1025, 1'b0, 1'b0, 0, 0);
		add_row(-1, 1500, 1'b0, 1'b0, 0, 0);
		add_row(1023, 300, 1'b0, 1'b0, 0, 0);
		add_row(-1024, 700, 1'b0, 1'b0, 0, 0);
		add_row(32, 0, 1'b0, 1'b0, 0, 0);
		add_row(31, 0, 1'b0, 1'b0, 0, 0);
		add_row(-32767, 1024, 1'b0, 1'b0, 0, 0);
		add_row(16384, 0, 1'b0, 1'b0, 0, 0);
		add_row(-16384, 1024, 1'b1, 1'b0, 0, 0);
		add_row(0, 0, 1'b1, 1'b0, 0, 0);
		add_row(-32768, 1024, 1'b0, 1'b0, 0, 0);
		add_row(21845, 1365, 1'b0, 1'b0, 0, 0);
		add_row(-21846, 682, 1'b0, 1'b0, 0, 0);
		add_row(32767, 2047, 1'b1, 1'b0, 0, 0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			offer_pair(stim_table[i].pair, stim_table[i].typed, stim_table[i].res);
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			blen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int k = 0; k < blen; k++) begin
				it.logit = rand_logit();
				it.target = rand_target();
				it.last_item = (k == blen - 1);
				if (sent == 100) begin
					hold_req = 1'b1;
				end
				if (sent == 250) begin
					quiet = 1'b1;
				end
				if (sent == 400) begin
					quiet = 1'b0;
				end
				if (sent == 450) begin
					item_valid <= 1'b0;
					@(negedge clk);
					while (due_results.size() != 0) @(negedge clk);
				end
				offer_pair(it, 1'b0, '0);
				sent++;
			end
		end
		item_valid <= 1'b0;

		while (due_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sigmoid_cross_entropy_loss.f -----
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_front.sv
rtl/sce_queue.sv
rtl/sce_div.sv
rtl/sce_back.sv
rtl/sigmoid_cross_entropy_loss.sv
rtl/sce_checker.sv
bench/tb_sigmoid_cross_entropy_loss.sv
